// ----- hdl/hrc_pkg.sv -----
// Shared types, codes and default sizes for the history ring with cursor.
package hrc_pkg;

    localparam int DEPTH_DEFAULT       = 128;
    localparam int ENTRY_WIDTH_DEFAULT = 32;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_PREV   = 3'd1;
    localparam logic [2:0] OP_NEXT   = 3'd2;
    localparam logic [2:0] OP_RECALL = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] entry_value;
        logic [7:0]  recall_number;
    } hrc_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] entry_out;
        logic [7:0]  entries_held;
    } hrc_out_t;

    typedef struct packed {
        logic [1:0] status;
        logic       use_value;
        logic [7:0] entries_held;
    } hrc_res_t;

endpackage

// ----- hdl/hrc_ram.sv -----
// Generic single-port-write, registered-read RAM.
module hrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/hrc_ctl.sv -----
// Ring pointers, cursor state and the per-command decision logic.
module hrc_ctl import hrc_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  hrc_in_t                cmd,
    output logic                   wr_en,
    output logic [IW-1:0]          wr_addr,
    output logic [ENTRY_WIDTH-1:0] wr_data,
    output logic [IW-1:0]          rd_addr,
    output hrc_res_t               res
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [IW-1:0] LAST    = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL    = CW'(DEPTH);
    localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);

    logic [IW-1:0] oldest_reg, oldest_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [CW-1:0] held_reg, held_next;
    logic          active_reg, active_next;

    logic [IW-1:0] newest_slot;
    logic [IW-1:0] recall_slot;
    logic          recall_ok;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[IW-1:0];
    endfunction

    assign newest_slot = wrap_add(oldest_reg, IW'(held_reg - CW'(1)));
    assign recall_slot = wrap_add(oldest_reg, IW'(cmd.recall_number - 8'd1));
    assign recall_ok   = (cmd.recall_number != 8'd0)
                      && (CMPW'(cmd.recall_number) <= CMPW'(held_reg));

    always_comb
    begin
        oldest_next   = oldest_reg;
        cursor_next   = cursor_reg;
        held_next     = held_reg;
        active_next   = active_reg;
        wr_en         = 1'b0;
        wr_addr       = oldest_reg;
        wr_data       = ENTRY_WIDTH'(cmd.entry_value);
        rd_addr       = cursor_reg;
        res.status    = ST_DONE;
        res.use_value = 1'b0;

        case (cmd.opcode)
            OP_ADD:
            begin
                wr_en = step;
                if (held_reg < FULL)
                begin
                    wr_addr   = wrap_add(oldest_reg, IW'(held_reg));
                    held_next = held_reg + CW'(1);
                end
                else
                begin
                    wr_addr     = oldest_reg;
                    oldest_next = (oldest_reg == LAST) ? '0 : oldest_reg + IW'(1);
                end
                active_next = 1'b0;
            end
            OP_PREV:
            begin
                if (held_reg == '0)
                begin
                    res.status = ST_NONE;
                end
                else
                begin
                    if (!active_reg)
                    begin
                        cursor_next = newest_slot;
                        active_next = 1'b1;
                    end
                    else if (cursor_reg != oldest_reg)
                    begin
                        cursor_next = (cursor_reg == '0) ? LAST : cursor_reg - IW'(1);
                    end
                    rd_addr       = cursor_next;
                    res.use_value = 1'b1;
                end
            end
            OP_NEXT:
            begin
                if (!active_reg || held_reg == '0)
                begin
                    active_next = 1'b0;
                    res.status  = ST_NONE;
                end
                else if (cursor_reg != newest_slot)
                begin
                    cursor_next   = (cursor_reg == LAST) ? '0 : cursor_reg + IW'(1);
                    rd_addr       = cursor_next;
                    res.use_value = 1'b1;
                end
                else
                begin
                    active_next = 1'b0;
                    res.status  = ST_END;
                end
            end
            OP_RECALL:
            begin
                if (recall_ok)
                begin
                    rd_addr       = recall_slot;
                    res.use_value = 1'b1;
                end
                else
                begin
                    res.status = ST_NONE;
                end
            end
            OP_CLEAR:
            begin
                held_next   = '0;
                oldest_next = '0;
                cursor_next = '0;
                active_next = 1'b0;
            end
            default:
            begin
                res.status = ST_NONE;
            end
        endcase

        res.entries_held = 8'(held_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            cursor_reg <= '0;
            held_reg   <= '0;
            active_reg <= 1'b0;
        end
        else if (step)
        begin
            oldest_reg <= oldest_next;
            cursor_reg <= cursor_next;
            held_reg   <= held_next;
            active_reg <= active_next;
        end
    end

endmodule

// ----- hdl/history_ring_with_cursor.sv -----
// Top level of the history ring with browse cursor.
// The block accepts one command beat per clock while the command side does not stall and
// returns one result beat for each, passed through the command register and then the
// store's registered read port, which also serves as the result register. Every command
// reads or writes at most one store entry, so the single write port and single read port
// of the store set the rate. Entries never written read as undefined; no clearing pass runs
// after reset. A stall on the result side holds the pipeline, and the command side then
// stalls only once the command register is also occupied.
module history_ring_with_cursor import hrc_pkg::*; #(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  hrc_in_t  cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output hrc_out_t rsp
);

    localparam int IW = $clog2(DEPTH);

    hrc_in_t  cmd_reg;
    logic     cmd_valid_reg, cmd_valid_next;
    logic     rsp_valid_reg, rsp_valid_next;
    hrc_res_t res_reg;
    hrc_res_t res;

    logic                   advance;
    logic                   step;
    logic                   accept;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic [IW-1:0]          rd_addr;
    logic [ENTRY_WIDTH-1:0] rd_data;

    assign advance = !rsp_valid_reg || !rsp_stall;
    assign step    = cmd_valid_reg && advance;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign accept  = cmd_valid && !cmd_stall;

    assign cmd_valid_next = accept ? 1'b1 : (advance ? 1'b0 : cmd_valid_reg);
    assign rsp_valid_next = advance ? cmd_valid_reg : rsp_valid_reg;

    hrc_ctl #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_ctl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cmd     (cmd_reg),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .res     (res)
    );

    hrc_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (step),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (step)
        begin
            res_reg <= res;
        end
    end

    always_comb
    begin
        rsp.status       = res_reg.status;
        rsp.entry_out    = res_reg.use_value ? 32'(rd_data) : '0;
        rsp.entries_held = res_reg.entries_held;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- hdl/hrc_check.sv -----
// Port-level checks for the history ring with cursor, bound to the top level.
module hrc_check import hrc_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic     clk,
    input logic     rst_n,
    input logic     cmd_valid,
    input logic     cmd_stall,
    input hrc_in_t  cmd,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input hrc_out_t rsp
);

    // A result that is held back must stay on the port unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // The command side stalls only when the result side is full and stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stalled without back-pressure");

    // A command beat reaches the result port through the command and result registers when nothing holds it.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !rsp_stall |=> rsp_valid)
        else $error("result beat missing after accepted command");

    // Only a returned entry carries a non-zero word.
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DONE |-> rsp.entry_out == '0)
        else $error("non-zero word with a failing status");

    // End of history needs a cursor, so the store cannot be empty.
    a_end_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_END |-> DEPTH > 255 || rsp.entries_held != 8'd0)
        else $error("end of history reported with an empty store");

endmodule

bind history_ring_with_cursor hrc_check #(.DEPTH(DEPTH)) u_check (.*);

// ----- tb/sv/history_ring_monitor.sv -----
// Channel monitor for the history ring: predicts each result beat and compares it field by field.
`timescale 1ns / 100ps

module history_ring_monitor import hrc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  logic     cmd_stall,
    input  hrc_in_t  cmd,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  hrc_out_t rsp,
    output int       fail_count,
    output int       outstanding,
    output int       checked
);

    localparam int SLOTS        = DEPTH_DEFAULT;
    localparam int REPORT_LIMIT = 40;

    logic [31:0] ring [SLOTS];
    int          oldest_slot = 0;
    int          held        = 0;
    int          cursor_slot = 0;
    bit          cursor_on   = 1'b0;

    hrc_out_t    replies_due [$];
    hrc_out_t    due;
    int          failures = 0;
    int          matched  = 0;

    function automatic hrc_out_t browse_history(input hrc_in_t c);
        hrc_out_t r;
        int       newest;
        r.status = ST_DONE;
        r.entry_out = '0;
        newest = (oldest_slot + held - 1 + SLOTS) % SLOTS;
        case (c.opcode)
            OP_ADD:
            begin
                if (held < SLOTS)
                begin
                    ring[(oldest_slot + held) % SLOTS] = c.entry_value;
                    held++;
                end
                else
                begin
                    ring[oldest_slot] = c.entry_value;
                    oldest_slot = (oldest_slot + 1) % SLOTS;
                end
                cursor_on = 1'b0;
            end
            OP_PREV:
            begin
                if (held == 0)
                    r.status = ST_NONE;
                else
                begin
                    if (!cursor_on)
                    begin
                        cursor_slot = newest;
                        cursor_on = 1'b1;
                    end
                    else if (cursor_slot != oldest_slot)
                        cursor_slot = (cursor_slot + SLOTS - 1) % SLOTS;
                    r.entry_out = ring[cursor_slot];
                end
            end
            OP_NEXT:
            begin
                if (!cursor_on || held == 0)
                begin
                    cursor_on = 1'b0;
                    r.status = ST_NONE;
                end
                else if (cursor_slot != newest)
                begin
                    cursor_slot = (cursor_slot + 1) % SLOTS;
                    r.entry_out = ring[cursor_slot];
                end
                else
                begin
                    cursor_on = 1'b0;
                    r.status = ST_END;
                end
            end
            OP_RECALL:
            begin
                if (c.recall_number == 8'd0 || int'(c.recall_number) > held)
                    r.status = ST_NONE;
                else
                    r.entry_out = ring[(oldest_slot + int'(c.recall_number) - 1) % SLOTS];
            end
            OP_CLEAR:
            begin
                held = 0;
                oldest_slot = 0;
                cursor_slot = 0;
                cursor_on = 1'b0;
            end
            default:
                r.status = ST_NONE;
        endcase
        r.entries_held = 8'(held);
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $error("%s: expected %0h, got %0h", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_slot = 0;
            held = 0;
            cursor_slot = 0;
            cursor_on = 1'b0;
            replies_due.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $error("result beat with no command awaiting it: status %0d, entry_out %0h",
                               rsp.status, rsp.entry_out);
                end
                else
                begin
                    due = replies_due.pop_front();
                    compare_field("status", 32'(due.status), 32'(rsp.status));
                    compare_field("entry_out", due.entry_out, rsp.entry_out);
                    compare_field("entries_held", 32'(due.entries_held), 32'(rsp.entries_held));
                    matched++;
                end
            end
            if (cmd_valid && !cmd_stall)
                replies_due.push_back(browse_history(cmd));
        end
        fail_count <= failures;
        outstanding <= replies_due.size();
        checked <= matched;
    end

endmodule

// ----- tb/sv/history_ring_with_cursor_test.sv -----
// Top of the history ring testbench: clock, reset, command and result stimulus, and verdict.
`timescale 1ns / 100ps

module history_ring_with_cursor_test import hrc_pkg::*;;

    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
    localparam int         RANDOM_ITEMS   = 1600;
    localparam int         HOLD_CYCLES    = 96;

    typedef enum int {FLOW, LIGHT, HEAVY, ALTERNATE, HOLD} stall_mode_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    hrc_in_t  cmd       = '0;
    logic     rsp_stall = 1'b0;
    logic     cmd_stall;
    logic     rsp_valid;
    hrc_out_t rsp;

    int fail_count;
    int outstanding;
    int checked;

    int burst_left   = 0;
    int sent_items   = 0;
    int held_guess   = 0;
    int add_count    = 0;
    int wrap_count   = 0;
    int browse_count = 0;
    int recall_count = 0;
    int clear_count  = 0;
    int spare_count  = 0;

    history_ring_with_cursor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    history_ring_monitor ring_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("history_ring_with_cursor verification failed");
        $finish;
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [7:0] pick_number();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'(held_guess);
            2: return 8'(held_guess + 1);
            3: return 8'($urandom_range(0, 255));
            default: return (held_guess == 0) ? 8'd1 : 8'($urandom_range(1, held_guess));
        endcase
    endfunction

    task automatic send(input logic [2:0] op, input logic [31:0] word, input logic [7:0] num);
        hrc_in_t beat;
        int      gap;
        beat.opcode = op;
        beat.entry_value = word;
        beat.recall_number = num;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd <= beat;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        case (op)
            OP_ADD:
            begin
                add_count++;
                if (held_guess == DEPTH_DEFAULT)
                    wrap_count++;
                else
                    held_guess++;
            end
            OP_PREV, OP_NEXT:
                browse_count++;
            OP_RECALL:
                recall_count++;
            OP_CLEAR:
            begin
                clear_count++;
                held_guess = 0;
            end
            default:
                spare_count++;
        endcase
        if (op <= OP_CLEAR)
            sent_items++;
    endtask

    task automatic send_op(input logic [2:0] op);
        send(op, rand_word(), pick_number());
    endtask

    initial
    begin : receiver
        stall_mode_t mode;
        int          span;
        int          beats;
        int          holds_done;
        beats = 0;
        holds_done = 0;
        wait (rst_n);
        forever
        begin
            mode = stall_mode_t'($urandom_range(FLOW, ALTERNATE));
            span = $urandom_range(1, 40);
            if (holds_done < 2 && beats >= 250 + holds_done * 750)
            begin
                mode = HOLD;
                span = HOLD_CYCLES;
                holds_done++;
            end
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (rsp_valid && !rsp_stall)
                    beats++;
                case (mode)
                    FLOW:      rsp_stall <= 1'b0;
                    LIGHT:     rsp_stall <= ($urandom_range(0, 3) == 0);
                    HEAVY:     rsp_stall <= ($urandom_range(0, 3) != 0);
                    ALTERNATE: rsp_stall <= k[0];
                    default:   rsp_stall <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int start;
        int episode;
        int n;
        int w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Browsing and recall on an empty store, then three adds.
        send(OP_PREV, rand_word(), 8'hFF);
        send(OP_NEXT, rand_word(), 8'h00);
        send(OP_RECALL, rand_word(), 8'd0);
        send(OP_RECALL, rand_word(), 8'd1);
        send(OP_ADD, 32'h0000_0000, 8'h00);
        send(OP_ADD, 32'hFFFF_FFFF, 8'hFF);
        send(OP_ADD, 32'hA5C3_0F96, 8'h80);
        // Walk back past the oldest entry, recall mid-browse, then forward past the newest.
        repeat (4) send_op(OP_PREV);
        send(OP_RECALL, rand_word(), 8'd2);
        repeat (4) send_op(OP_NEXT);
        send(OP_RECALL, rand_word(), 8'd1);
        send(OP_RECALL, rand_word(), 8'd3);
        send(OP_RECALL, rand_word(), 8'd4);
        send(OP_RECALL, rand_word(), 8'd255);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send(3'(op), rand_word(), pick_number());
        // An add drops the cursor.
        send_op(OP_PREV);
        send(OP_ADD, 32'h5A5A_C3C3, 8'h7F);
        send_op(OP_NEXT);
        send_op(OP_CLEAR);
        send_op(OP_PREV);

        start = sent_items;
        while (sent_items - start < RANDOM_ITEMS)
        begin
            episode = $urandom_range(0, 99);
            if (episode < 30)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 200) : $urandom_range(1, 12);
                repeat (n) send_op(OP_ADD);
            end
            else if (episode < 55)
            begin
                n = ($urandom_range(0, 3) == 0) ? held_guess + $urandom_range(0, 3)
                                                : $urandom_range(1, 6);
                repeat (n) send_op(OP_PREV);
                n = ($urandom_range(0, 3) == 0) ? held_guess + $urandom_range(0, 3)
                                                : $urandom_range(1, 6);
                repeat (n) send_op(OP_NEXT);
            end
            else if (episode < 75)
            begin
                repeat ($urandom_range(1, 8)) send_op(OP_RECALL);
            end
            else if (episode < 87)
            begin
                repeat ($urandom_range(1, 4))
                    send(3'($urandom_range(OP_ADD, OP_SPARE_LAST)), rand_word(),
                         8'($urandom_range(0, 255)));
            end
            else if (episode < 89)
            begin
                send_op(OP_CLEAR);
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                begin
                    case ($urandom_range(0, 4))
                        0, 1: send_op(OP_PREV);
                        2, 3: send_op(OP_NEXT);
                        default: send_op(OP_RECALL);
                    endcase
                end
            end
        end
        cmd_valid <= 1'b0;

        @(posedge clk);
        w = 0;
        while (outstanding != 0 && w < 20000)
        begin
            @(posedge clk);
            w++;
        end
        repeat (8) @(posedge clk);

        $display("Run covered %0d commands: %0d adds (%0d onto a full store), %0d browse steps,",
                 sent_items + spare_count, add_count, wrap_count, browse_count);
        $display("  %0d recalls, %0d clears and %0d unused codes; %0d result beats compared.",
                 recall_count, clear_count, spare_count, checked);
        if (fail_count == 0 && outstanding == 0)
            $display("history_ring_with_cursor verification clean");
        else
            $display("history_ring_with_cursor verification failed");
        $finish;
    end

endmodule
